// ----- hw/rtl/avtb_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// avtb_pkg: water volume table shared types and constants
// Request and result structs, op and status codes, table geometry.
// ---------------------------------------------------------------------------
package avtb_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         handle_index;
    logic [7:0]         handle_gen;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] surface_level;
    logic [31:0]        strength;
    logic [31:0]        drag_coeff;
    logic [31:0]        body_mass;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         out_index;
    logic [7:0]         out_gen;
    logic               underwater;
    logic [31:0]        depth;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
  } rsp_t;

  // one stored volume
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] surf;
    logic [31:0]        str;
    logic [31:0]        drag;
  } vol_t;

endpackage
`default_nettype wire

// ----- hw/rtl/avtb_mul.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// avtb_mul: shared 32x32 multiplier
// Registered unsigned product used by the scan and force sequence.
// ---------------------------------------------------------------------------
module avtb_mul (
  input  wire         clk,
  input  wire  [31:0] a,
  input  wire  [31:0] b,
  output logic [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aabb_volume_table_buoyancy.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// aabb_volume_table_buoyancy: handle-addressed water volume table
// Add, remove, update, clear and buoyancy query over a slot table.
// ---------------------------------------------------------------------------
// Usage: drive in_req and raise start while busy is low; the request is taken
// at that edge and busy stays high until the cycle of the result. Exactly one
// result per request appears on out_rsp for one cycle with out_valid high;
// the receiver cannot stall and must take it then. busy is low in the result
// cycle, so the next request can be taken at the edge that ends it.
// Every request first reads the generation memory at the lowest free slot
// and at the handle slot. Add, remove, update, clear and unknown ops then
// finish, and the result appears on the ports after S_CMD and S_OUT.
// A query walks slots 1..SLOT_COUNT-1 through the single-port volume memory,
// one slot at a time (read, test, multiply, accumulate) with each term's
// strength*depth product on the one shared 32x32 multiplier; with no
// containing volume the result follows the last slot. When a volume contains
// the point, the three force products reuse the same multiplier on 16-bit
// pieces, 8 pieces per product, each multiplied and then accumulated, and
// the forces are composed in a final step before the result.
// Reset clears the activity and generation valid bits at once; the
// generation and volume memories are not cleared, unset entries are never
// used.
// ---------------------------------------------------------------------------
module aabb_volume_table_buoyancy (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire  avtb_pkg::req_t in_req,
  output logic                 busy,
  output logic                 out_valid,
  output avtb_pkg::rsp_t       out_rsp
);
  localparam int SW = avtb_pkg::SLOT_W;
  localparam int CW = avtb_pkg::CNT_W;
  localparam int N  = avtb_pkg::SLOT_COUNT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMD   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_TEST  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_FMUL  = 4'd5;
  localparam logic [3:0] S_FACC  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_LOOK  = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;

  logic [3:0] state_r, state_nxt;
  avtb_pkg::req_t req_r;
  logic [N-1:0] act_r;
  // generation valid bits: an entry without one reads as zero
  logic [N-1:0] gok_r;
  logic [7:0]   gen_mem [N];
  logic [7:0]   gf_r, gh_r;
  logic [127:0] geo_mem [N];
  logic [95:0]  prop_mem [N];
  avtb_pkg::vol_t rd_r;
  logic [CW-1:0] idx_r;
  logic hit_r;
  logic [31:0] dep_r;
  logic [63:0] ssum_r;
  logic [38:0] dsum_r;
  logic [31:0] udep_r;
  logic [31:0] str_r;
  // force phase: job 0 buoyancy, 1 drag x, 2 drag y; 4 x 2 16-bit pieces
  logic [1:0] job_r;
  logic [3:0] pc_r;
  logic [95:0] facc_r;
  logic [97:0] mag_r [3];
  avtb_pkg::rsp_t rsp_r;
  avtb_pkg::rsp_t cmd_rsp;
  logic ov_r;

  // lowest free slot
  logic [SW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = N - 1; i >= 1; i--) begin
      if (!act_r[i]) begin
        free_idx = SW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  logic [SW-1:0] slot;
  assign slot = idx_r[SW-1:0];

  // generations at the free slot and at the handle slot
  logic [7:0] gfree, ghdl, gnew;
  assign gfree = gok_r[free_idx] ? gf_r : 8'd0;
  assign gnew  = (gfree == 8'hFF) ? 8'd1 : gfree + 8'd1;

  // handle check
  logic [SW-1:0] hslot;
  logic hv;
  assign hslot = SW'(req_r.handle_index);
  assign ghdl  = gok_r[hslot] ? gh_r : 8'd0;
  assign hv = (req_r.handle_index != 6'd0) && (32'(req_r.handle_index) < 32'(N))
              && act_r[hslot] && (ghdl == req_r.handle_gen);

  // shared multiplier operands
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] fop_a;
  logic [31:0] fop_b;
  logic [31:0] vmag_x, vmag_y;
  assign vmag_x = req_r.b_x[31] ? 32'(-req_r.b_x) : 32'(req_r.b_x);
  assign vmag_y = req_r.b_y[31] ? 32'(-req_r.b_y) : 32'(req_r.b_y);
  always_comb begin
    unique case (job_r)
      2'd0:    begin fop_a = ssum_r;        fop_b = req_r.body_mass; end
      2'd1:    begin fop_a = 64'(dsum_r);   fop_b = vmag_x; end
      default: begin fop_a = 64'(dsum_r);   fop_b = vmag_y; end
    endcase
    if (state_r == S_FMUL || state_r == S_FACC) begin
      ma = {16'd0, fop_a[16*pc_r[3:2] +: 16]};
      mb = {16'd0, fop_b[16*pc_r[1] +: 16]};
    end else begin
      ma = str_r;
      mb = udep_r;
    end
  end
  avtb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  // containment test on registered slot data
  logic signed [32:0] dx, dy;
  logic inx, iny;
  logic signed [32:0] dsurf;
  assign dx  = 33'(req_r.a_x) - 33'(rd_r.cx);
  assign dy  = 33'(req_r.a_y) - 33'(rd_r.cy);
  assign inx = (dx >= -33'(rd_r.hx)) && (dx <= 33'(rd_r.hx));
  assign iny = (dy >= -33'(rd_r.hy)) && (dy <= 33'(rd_r.hy));
  assign dsurf = 33'(req_r.a_y) - 33'(rd_r.surf);

  // final force composition
  localparam logic [97:0] CAP = 98'h1_0000_0000_0000;
  function automatic logic [48:0] capm(input logic [97:0] v);
    return (v > CAP) ? 49'(CAP) : v[48:0];
  endfunction
  function automatic logic signed [47:0] sat(input logic signed [51:0] v);
    if (v > 52'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -52'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction
  logic signed [51:0] fx_w, fy_w, bu_w, dyt_w;
  always_comb begin
    bu_w  = 52'(capm(mag_r[0]));
    fx_w  = req_r.b_x[31] ? 52'(capm(mag_r[1])) : -52'(capm(mag_r[1]));
    dyt_w = req_r.b_y[31] ? 52'(capm(mag_r[2])) : -52'(capm(mag_r[2]));
    fy_w  = dyt_w - bu_w;
  end

  // result of a request, settled in the command cycle
  always_comb begin
    cmd_rsp = '0;
    unique case (req_r.op)
      avtb_pkg::OP_ADD: begin
        cmd_rsp.status = free_ok ? avtb_pkg::ST_DONE : avtb_pkg::ST_FULL;
        if (free_ok) begin
          cmd_rsp.out_index = 6'(free_idx);
          cmd_rsp.out_gen   = gnew;
        end
      end
      avtb_pkg::OP_REMOVE, avtb_pkg::OP_UPDATE:
        cmd_rsp.status = hv ? avtb_pkg::ST_DONE : avtb_pkg::ST_STALE;
      avtb_pkg::OP_QUERY, avtb_pkg::OP_CLEAR: cmd_rsp.status = avtb_pkg::ST_DONE;
      default: cmd_rsp.status = avtb_pkg::ST_STALE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_CMD;
      S_CMD:  state_nxt = (req_r.op == avtb_pkg::OP_QUERY) ? S_RD : S_OUT;
      S_RD:   state_nxt = S_TEST;
      S_TEST: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (idx_r == CW'(N - 1)) ? (hit_r ? S_FMUL : S_OUT) : S_RD;
      S_FMUL: state_nxt = S_FACC;
      S_FACC: state_nxt = (pc_r == 4'd14) ? ((job_r == 2'd2) ? S_FIN : S_FMUL) : S_FMUL;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      gok_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_OUT);
      if (state_r == S_CMD) begin
        unique case (req_r.op)
          avtb_pkg::OP_ADD: if (free_ok) begin
            act_r[free_idx] <= 1'b1;
            gok_r[free_idx] <= 1'b1;
          end
          avtb_pkg::OP_REMOVE: if (hv) act_r[hslot] <= 1'b0;
          avtb_pkg::OP_CLEAR: begin
            act_r <= '0;
            gok_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // generation memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      gf_r <= gen_mem[free_idx];
      gh_r <= gen_mem[hslot];
    end
    if (state_r == S_CMD && req_r.op == avtb_pkg::OP_ADD && free_ok)
      gen_mem[free_idx] <= gnew;
  end

  // volume memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == S_CMD && req_r.op == avtb_pkg::OP_ADD && free_ok) begin
      geo_mem[free_idx]  <= {req_r.a_x, req_r.a_y, req_r.b_x, req_r.b_y};
      prop_mem[free_idx] <= {req_r.surface_level, req_r.strength, req_r.drag_coeff};
    end else if (state_r == S_CMD && req_r.op == avtb_pkg::OP_UPDATE && hv) begin
      geo_mem[hslot] <= {req_r.a_x, req_r.a_y, req_r.b_x, req_r.b_y};
    end
    if (state_r == S_RD) rd_r <= {geo_mem[slot], prop_mem[slot]};
  end

  logic incl_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_req;
    unique case (state_r)
      S_CMD: begin
        idx_r  <= CW'(1);
        hit_r  <= 1'b0;
        dep_r  <= '0;
        ssum_r <= '0;
        dsum_r <= '0;
        job_r  <= 2'd0;
        pc_r   <= 4'd0;
        facc_r <= '0;
        rsp_r  <= cmd_rsp;
      end
      S_TEST: begin
        incl_r <= act_r[slot] && inx && iny;
        udep_r <= (dsurf > 0) ? dsurf[31:0] : 32'd0;
        str_r  <= rd_r.str;
        if (act_r[slot] && inx && iny) begin
          if (!hit_r) dep_r <= (dsurf > 0) ? dsurf[31:0] : 32'd0;
          hit_r  <= 1'b1;
          dsum_r <= dsum_r + 39'(rd_r.drag);
        end
      end
      S_ACC: begin
        if (incl_r) ssum_r <= ssum_r + 64'(mp[63:16]);
        idx_r <= idx_r + CW'(1);
      end
      S_FACC: begin
        if (pc_r == 4'd14) begin
          mag_r[job_r] <= 98'((facc_r + (96'(mp) << (16*(pc_r[3:2] + 2'(pc_r[1])))))
                              >> 16);
          facc_r <= '0;
          job_r  <= job_r + 2'd1;
        end else begin
          facc_r <= facc_r + (96'(mp) << (16*(pc_r[3:2] + 2'(pc_r[1]))));
        end
        // pc bit 0 is unused: pc steps by two and wraps to zero per job
        pc_r <= pc_r + 4'd2;
      end
      S_FIN: begin
        rsp_r.underwater <= 1'b1;
        rsp_r.depth      <= dep_r;
        rsp_r.force_x    <= sat(fx_w);
        rsp_r.force_y    <= sat(fy_w);
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;

endmodule
`default_nettype wire

// ----- hw/rtl/avtb_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// avtb_checker: port-level checks for the volume table
// Result pulses and busy behavior seen at the top level.
// ---------------------------------------------------------------------------
module avtb_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input wire avtb_pkg::rsp_t out_rsp
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status != 2'd3) else $error("bad status");
endmodule

bind aabb_volume_table_buoyancy avtb_checker u_avtb_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp)
);
`default_nettype wire
